[design/ltdg_pkg.sv]
// Shared types and constants for the landing target descent gate.
// Used by every module of the block but the multiplier; depends on nothing.
package ltdg_pkg;

	// Default values of the top level parameters.
	localparam int CONF_FRAC_BITS_DEF  = 16;
	localparam int PIXEL_FRAC_BITS_DEF = 4;

	// Fixed field widths.
	localparam int PIX_W     = 16;
	localparam int SIZE_W    = 13;
	localparam int MMPP_W    = 16;
	localparam int MMPP_FRAC = 8;
	localparam int ALIGN_W   = 16;
	localparam int ERR_W     = 21;
	localparam int SQ_W      = 2 * ERR_W - 1;
	localparam int CFG_IDX_W = 3;

	// Register reset values that do not depend on the confidence format.
	localparam int RST_MMPP   = 256;
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;
	localparam int RST_ALIGN  = 300;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MM_PER_PIXEL       = 3'd0,
		REG_IMAGE_WIDTH        = 3'd1,
		REG_IMAGE_HEIGHT       = 3'd2,
		REG_CONFIDENCE_STEP    = 3'd3,
		REG_DECAY_FACTOR       = 3'd4,
		REG_ACQUIRE_LEVEL      = 3'd5,
		REG_ALIGN_THRESHOLD_MM = 3'd6
	} reg_idx_t;

	// Sequencer commands to one axis lane.
	typedef struct packed {
		logic load;
		logic start_scale;
		logic latch_err;
		logic start_square;
	} lane_ctrl_t;

endpackage

[design/landing_target_descent_gate.sv]
// Landing target descent gate.
// One observation word enters on the input channel (in_valid / in_stall):
// a detected flag and the pad centre in sub-pixel units. One result word
// leaves on the output channel (out_valid / out_stall) for every accepted
// observation: the last known centre error in millimetres, the confidence,
// and the acquired and descend_ok flags.
// The work per frame is done by the bit-serial multipliers: a detected frame
// runs two 21-step passes in the axis lanes (scale to millimetres, then
// square), a missed frame one 17-step pass (confidence times decay). The
// block holds in_stall high from acceptance until the result is loaded, so
// one observation is in work at a time and the next is taken in the cycle
// after that. A new observation is taken while the previous result still
// waits in the output register.
// Reset clears the confidence, the stored errors and both flags, and loads
// the register defaults. If the receiver stalls, the result stays in the
// output register unchanged and the next finished result waits until that
// word is taken. Configuration writes (cfg_valid / cfg_ready) are to be
// made while the block is idle; the block itself does not enforce this.
module landing_target_descent_gate #(
	parameter int CONF_FRAC_BITS  = ltdg_pkg::CONF_FRAC_BITS_DEF,
	parameter int PIXEL_FRAC_BITS = ltdg_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [ltdg_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [((CONF_FRAC_BITS + 1 > ltdg_pkg::ALIGN_W) ?
		CONF_FRAC_BITS + 1 : ltdg_pkg::ALIGN_W)-1:0]    cfg_data,
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  logic                                     detected,
	input  logic [ltdg_pkg::PIX_W-1:0]               center_x,
	input  logic [ltdg_pkg::PIX_W-1:0]               center_y,
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output logic signed [ltdg_pkg::ERR_W-1:0]        error_x_mm,
	output logic signed [ltdg_pkg::ERR_W-1:0]        error_y_mm,
	output logic [CONF_FRAC_BITS:0]                  confidence,
	output logic                                     acquired,
	output logic                                     descend_ok
);

	localparam int CW     = CONF_FRAC_BITS + 1;
	localparam int ALW    = ltdg_pkg::ALIGN_W;
	localparam int CFG_DW = (CW > ALW) ? CW : ALW;
	localparam int CMW    = (CW > ALW) ? CW : ALW;
	localparam int SQ_W   = ltdg_pkg::SQ_W;
	localparam int ONE_I  = 1 << CONF_FRAC_BITS;
	// Defaults of one tenth, eight tenths and seven tenths, rounded.
	localparam int RST_STEP   = (ONE_I + 5) / 10;
	localparam int RST_DECAY  = (ONE_I * 8 + 5) / 10;
	localparam int RST_THRESH = (ONE_I * 7 + 5) / 10;
	localparam logic [CW-1:0] CONF_ONE = {1'b1, {CONF_FRAC_BITS{1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SCALE,
		ST_SQLOAD,
		ST_SQUARE,
		ST_RESULT
	} state_t;

	state_t state_q;

	logic [ltdg_pkg::MMPP_W-1:0] mm_per_pixel;
	logic [ltdg_pkg::SIZE_W-1:0] image_width;
	logic [ltdg_pkg::SIZE_W-1:0] image_height;
	logic [CW-1:0]               confidence_step;
	logic [CW-1:0]               decay_factor;
	logic [CW-1:0]               acquire_level;
	logic [ALW-1:0]              align_threshold_mm;

	ltdg_pkg::lane_ctrl_t lane_ctrl;

	logic                          in_acc;
	logic                          out_free;
	logic                          res_load;
	logic                          det_q;
	logic                          busy_x;
	logic                          busy_y;
	logic                          busy_c;
	logic                          busy_all;
	logic signed [ltdg_pkg::ERR_W-1:0] lane_err_x;
	logic signed [ltdg_pkg::ERR_W-1:0] lane_err_y;
	logic [SQ_W-1:0]               sq_x;
	logic [SQ_W-1:0]               sq_y;
	logic                          c_start;
	logic [CMW-1:0]                c_a;
	logic [CMW-1:0]                c_b;
	logic [2*CMW-1:0]              c_prod;
	logic [CW:0]                   conf_sum;
	logic [CW:0]                   conf_dec;
	logic [CW:0]                   conf_raw;
	logic [CW-1:0]                 conf_next;
	logic                          acq_next;
	logic [SQ_W:0]                 dist2;
	logic [SQ_W:0]                 lim2;
	logic                          desc_next;

	logic                          out_valid_q;
	logic signed [ltdg_pkg::ERR_W-1:0] err_x_q;
	logic signed [ltdg_pkg::ERR_W-1:0] err_y_q;
	logic [CW-1:0]                 conf_q;
	logic                          acq_q;
	logic                          desc_q;

	ltdg_cfg #(
		.CONF_W     (CW),
		.DATA_W     (CFG_DW),
		.RST_STEP   (RST_STEP),
		.RST_DECAY  (RST_DECAY),
		.RST_THRESH (RST_THRESH)
	) u_cfg (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.mm_per_pixel       (mm_per_pixel),
		.image_width        (image_width),
		.image_height       (image_height),
		.confidence_step    (confidence_step),
		.decay_factor       (decay_factor),
		.acquire_level      (acquire_level),
		.align_threshold_mm (align_threshold_mm)
	);

	// Input is taken only when the sequencer is idle; the output register
	// decouples the receiver.
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign out_free = ~out_valid_q | ~out_stall;
	assign res_load = (state_q == ST_RESULT) & out_free;
	assign busy_all = busy_x | busy_y | busy_c;

	always_comb begin
		lane_ctrl.load         = in_acc;
		lane_ctrl.start_scale  = (state_q == ST_LOAD) & det_q;
		lane_ctrl.latch_err    = (state_q == ST_SCALE) & ~busy_all & det_q;
		lane_ctrl.start_square = (state_q == ST_SQLOAD);
	end

	ltdg_lane #(
		.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
	) u_lane_x (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (lane_ctrl),
		.center       (center_x),
		.size         (image_width),
		.mm_per_pixel (mm_per_pixel),
		.busy         (busy_x),
		.err          (lane_err_x),
		.sq           (sq_x)
	);

	ltdg_lane #(
		.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
	) u_lane_y (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (lane_ctrl),
		.center       (center_y),
		.size         (image_height),
		.mm_per_pixel (mm_per_pixel),
		.busy         (busy_y),
		.err          (lane_err_y),
		.sq           (sq_y)
	);

	// Shared serial multiplier: squares the align threshold on a detected
	// frame, and applies the decay to the confidence on a missed frame.
	assign c_start = (state_q == ST_LOAD);
	assign c_a     = det_q ? CMW'(align_threshold_mm) : CMW'(conf_q);
	assign c_b     = det_q ? CMW'(align_threshold_mm) : CMW'(decay_factor);

	ltdg_bsmul #(
		.A_W(CMW),
		.B_W(CMW)
	) u_mul_c (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (c_start),
		.a      (c_a),
		.b      (c_b),
		.busy   (busy_c),
		.prod   (c_prod)
	);

	// Confidence update: saturating add on a hit, truncating decay on a miss, both clipped at one.
	assign conf_sum  = {1'b0, conf_q} + {1'b0, confidence_step};
	assign conf_dec  = c_prod[2*CW-1:CONF_FRAC_BITS];
	assign conf_raw  = det_q ? conf_sum : conf_dec;
	assign conf_next = (conf_raw > {1'b0, CONF_ONE}) ? CONF_ONE : conf_raw[CW-1:0];
	assign acq_next  = (conf_next >= acquire_level);

	// Descent needs the squared error distance within the squared threshold.
	assign dist2     = {1'b0, sq_x} + {1'b0, sq_y};
	assign lim2      = (SQ_W + 1)'(c_prod[2*ALW-1:0]);
	assign desc_next = det_q & acq_next & (dist2 <= lim2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			det_q       <= 1'b0;
			out_valid_q <= 1'b0;
			err_x_q     <= '0;
			err_y_q     <= '0;
			conf_q      <= '0;
			acq_q       <= 1'b0;
			desc_q      <= 1'b0;
		end else begin
			// A new result replaces the word being taken in the same cycle.
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						det_q   <= detected;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (!busy_all) begin
						state_q <= det_q ? ST_SQLOAD : ST_RESULT;
					end
				end
				ST_SQLOAD: begin
					state_q <= ST_SQUARE;
				end
				ST_SQUARE: begin
					if (!busy_all) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						if (det_q) begin
							err_x_q <= lane_err_x;
							err_y_q <= lane_err_y;
						end
						conf_q  <= conf_next;
						acq_q   <= acq_next;
						desc_q  <= desc_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign error_x_mm = err_x_q;
	assign error_y_mm = err_y_q;
	assign confidence = conf_q;
	assign acquired   = acq_q;
	assign descend_ok = desc_q;

endmodule

[design/ltdg_cfg.sv]
// Configuration register file of the descent gate.
// Depends on ltdg_pkg for register indexes and field widths.
module ltdg_cfg #(
	parameter int CONF_W     = ltdg_pkg::CONF_FRAC_BITS_DEF + 1,
	parameter int DATA_W     = ltdg_pkg::ALIGN_W,
	parameter int RST_STEP   = 6554,
	parameter int RST_DECAY  = 52429,
	parameter int RST_THRESH = 45875
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [ltdg_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]              cfg_data,
	output logic [ltdg_pkg::MMPP_W-1:0]    mm_per_pixel,
	output logic [ltdg_pkg::SIZE_W-1:0]    image_width,
	output logic [ltdg_pkg::SIZE_W-1:0]    image_height,
	output logic [CONF_W-1:0]              confidence_step,
	output logic [CONF_W-1:0]              decay_factor,
	output logic [CONF_W-1:0]              acquire_level,
	output logic [ltdg_pkg::ALIGN_W-1:0]   align_threshold_mm
);

	logic wr;

	// Writes are always taken.
	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid & cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_per_pixel       <= ltdg_pkg::MMPP_W'(ltdg_pkg::RST_MMPP);
			image_width        <= ltdg_pkg::SIZE_W'(ltdg_pkg::RST_WIDTH);
			image_height       <= ltdg_pkg::SIZE_W'(ltdg_pkg::RST_HEIGHT);
			confidence_step    <= CONF_W'(RST_STEP);
			decay_factor       <= CONF_W'(RST_DECAY);
			acquire_level      <= CONF_W'(RST_THRESH);
			align_threshold_mm <= ltdg_pkg::ALIGN_W'(ltdg_pkg::RST_ALIGN);
		end else if (wr) begin
			unique case (cfg_index)
				ltdg_pkg::REG_MM_PER_PIXEL: begin
					mm_per_pixel <= cfg_data[ltdg_pkg::MMPP_W-1:0];
				end
				ltdg_pkg::REG_IMAGE_WIDTH: begin
					image_width <= cfg_data[ltdg_pkg::SIZE_W-1:0];
				end
				ltdg_pkg::REG_IMAGE_HEIGHT: begin
					image_height <= cfg_data[ltdg_pkg::SIZE_W-1:0];
				end
				ltdg_pkg::REG_CONFIDENCE_STEP: begin
					confidence_step <= cfg_data[CONF_W-1:0];
				end
				ltdg_pkg::REG_DECAY_FACTOR: begin
					decay_factor <= cfg_data[CONF_W-1:0];
				end
				ltdg_pkg::REG_ACQUIRE_LEVEL: begin
					acquire_level <= cfg_data[CONF_W-1:0];
				end
				ltdg_pkg::REG_ALIGN_THRESHOLD_MM: begin
					align_threshold_mm <= cfg_data[ltdg_pkg::ALIGN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[design/ltdg_bsmul.sv]
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Standalone; used by the axis lanes and the top level sequencer.
module ltdg_bsmul #(
	parameter int A_W = 21,
	parameter int B_W = 21
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic               busy,
	output logic [A_W+B_W-1:0] prod
);

	localparam int CNT_W = $clog2(B_W + 1);

	logic [CNT_W-1:0]   cnt_q;
	logic [A_W-1:0]     a_q;
	logic [A_W+B_W-1:0] acc_q;
	logic [A_W:0]       sum;

	// The low half of the accumulator starts as the multiplier and shifts out
	// one bit per step while the partial sum grows into the high half.
	assign sum  = {1'b0, acc_q[A_W+B_W-1:B_W]} + (acc_q[0] ? {1'b0, a_q} : '0);
	assign busy = (cnt_q != '0);
	assign prod = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(B_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{A_W{1'b0}}, b};
		end else if (busy) begin
			acc_q <= {sum, acc_q[B_W-1:1]};
		end
	end

endmodule

[design/ltdg_lane.sv]
// One axis of the centre error: offset from image centre, scaling to
// millimetres with rounding and saturation, and the squared error.
// Depends on ltdg_pkg and ltdg_bsmul.
module ltdg_lane #(
	parameter int PIXEL_FRAC_BITS = ltdg_pkg::PIXEL_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ltdg_pkg::lane_ctrl_t                ctrl,
	input  logic [ltdg_pkg::PIX_W-1:0]          center,
	input  logic [ltdg_pkg::SIZE_W-1:0]         size,
	input  logic [ltdg_pkg::MMPP_W-1:0]         mm_per_pixel,
	output logic                                busy,
	output logic signed [ltdg_pkg::ERR_W-1:0]   err,
	output logic [ltdg_pkg::SQ_W-1:0]           sq
);

	localparam int ERR_W = ltdg_pkg::ERR_W;
	localparam int MID_W = ltdg_pkg::SIZE_W + PIXEL_FRAC_BITS;
	localparam int MAG_W = (MID_W > ltdg_pkg::PIX_W + 1) ? MID_W : ltdg_pkg::PIX_W + 1;
	localparam int LA_W  = (MAG_W > ERR_W) ? MAG_W : ERR_W;
	localparam int PW    = MAG_W + ltdg_pkg::MMPP_W;
	localparam int SH    = ltdg_pkg::MMPP_FRAC + 1 + PIXEL_FRAC_BITS;
	localparam int MM_W  = PW + 1 - SH;
	localparam logic [PW:0]      RND     = {{(PW + 1 - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};
	localparam logic [ERR_W-1:0] POS_MAX = {1'b0, {(ERR_W - 1){1'b1}}};
	localparam logic [ERR_W-1:0] NEG_MAG = {1'b1, {(ERR_W - 1){1'b0}}};

	logic [MAG_W-1:0]      twice;
	logic [MAG_W-1:0]      mid;
	logic                  neg_c;
	logic [MAG_W-1:0]      mag_c;
	logic [MAG_W-1:0]      mag_q;
	logic                  neg_q;
	logic [ERR_W-1:0]      emag_q;
	logic [ERR_W-1:0]      emag_c;
	logic signed [ERR_W-1:0] err_q;
	logic [LA_W-1:0]       mul_a;
	logic [ERR_W-1:0]      mul_b;
	logic [LA_W+ERR_W-1:0] prod;
	logic [PW:0]           rsum;
	logic [MM_W-1:0]       mm;
	logic                  big;

	// Offset in half-fraction units so an odd image size is centred exactly.
	assign twice = MAG_W'({center, 1'b0});
	assign mid   = MAG_W'(size) << PIXEL_FRAC_BITS;
	assign neg_c = twice < mid;
	assign mag_c = neg_c ? (mid - twice) : (twice - mid);

	// First pass multiplies the offset by the scale, second pass squares the
	// saturated error magnitude.
	assign mul_a = ctrl.start_square ? LA_W'(emag_q) : LA_W'(mag_q);
	assign mul_b = ctrl.start_square ? emag_q : ERR_W'(mm_per_pixel);

	ltdg_bsmul #(
		.A_W(LA_W),
		.B_W(ERR_W)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.start_scale | ctrl.start_square),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (busy),
		.prod   (prod)
	);

	// Round half away from zero on the magnitude, then clamp.
	assign rsum   = {1'b0, prod[PW-1:0]} + RND;
	assign mm     = rsum[PW:SH];
	assign big    = |mm[MM_W-1:ERR_W-1];
	assign emag_c = big ? (neg_q ? NEG_MAG : POS_MAX) : {1'b0, mm[ERR_W-2:0]};

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= mag_c;
			neg_q <= neg_c;
		end
		if (ctrl.latch_err) begin
			emag_q <= emag_c;
			err_q  <= neg_q ? -$signed(emag_c) : $signed(emag_c);
		end
	end

	assign err = err_q;
	assign sq  = prod[ltdg_pkg::SQ_W-1:0];

endmodule

[design/ltdg_checker.sv]
// Port-level checks for the landing target descent gate, bound to the top.
// Depends on ltdg_pkg for field widths.
module ltdg_checker #(
	parameter int CONF_FRAC_BITS = ltdg_pkg::CONF_FRAC_BITS_DEF
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 in_valid,
	input logic                                 in_stall,
	input logic                                 out_valid,
	input logic                                 out_stall,
	input logic signed [ltdg_pkg::ERR_W-1:0]    error_x_mm,
	input logic signed [ltdg_pkg::ERR_W-1:0]    error_y_mm,
	input logic [CONF_FRAC_BITS:0]              confidence,
	input logic                                 acquired,
	input logic                                 descend_ok
);

	localparam logic [CONF_FRAC_BITS:0] CONF_ONE = {1'b1, {CONF_FRAC_BITS{1'b0}}};

	// A result held by the receiver keeps its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(error_x_mm) &&
			$stable(error_y_mm) && $stable(confidence) && $stable(acquired) &&
			$stable(descend_ok))
		else $error("result word changed while stalled");

	// Confidence never passes one.
	a_conf_max: assert property (@(posedge clk) disable iff (!arst_n)
		confidence <= CONF_ONE)
		else $error("confidence above one");

	// Descent is only allowed on an acquired target.
	a_desc_acq: assert property (@(posedge clk) disable iff (!arst_n)
		descend_ok |-> acquired)
		else $error("descend_ok without acquired");

	// One observation is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after an accept");

endmodule

bind landing_target_descent_gate ltdg_checker #(
	.CONF_FRAC_BITS(CONF_FRAC_BITS)
) u_ltdg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.error_x_mm  (error_x_mm),
	.error_y_mm  (error_y_mm),
	.confidence  (confidence),
	.acquired    (acquired),
	.descend_ok  (descend_ok)
);

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the landing target descent gate.
// Depends on ltdg_pkg and the landing_target_descent_gate top level only.

module testbench;
	import ltdg_pkg::*;

	localparam int CONF_W = CONF_FRAC_BITS_DEF + 1;
	localparam int CFG_W = (CONF_W > ALIGN_W) ? CONF_W : ALIGN_W;
	localparam longint CONF_ONE = longint'(1) << CONF_FRAC_BITS_DEF;
	// The doubled offset carries one extra fraction bit, the scale eight more.
	localparam int MM_SHIFT = MMPP_FRAC + 1 + PIXEL_FRAC_BITS_DEF;
	localparam longint ERR_LIMIT = longint'(1) << (ERR_W - 1);
	localparam int RST_STEP = 6554;
	localparam int RST_DECAY = 52429;
	localparam int RST_CONFIRM = 45875;
	// The index field has room for one slot past the register list.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = '1;
	localparam int REG_SLOTS = 1 << CFG_IDX_W;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_FRAMES = 145;

	// One result word as the block should present it.
	typedef struct {
		logic signed [ERR_W-1:0] err_x;
		logic signed [ERR_W-1:0] err_y;
		logic [CONF_W-1:0] conf;
		logic acq;
		logic desc;
	} gate_word_t;

	// Values for every slot of the register index, the unused one included.
	typedef logic [CFG_W-1:0] reg_file_t [REG_SLOTS];

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic detected;
	logic [PIX_W-1:0] center_x;
	logic [PIX_W-1:0] center_y;
	logic out_valid;
	logic out_stall;
	logic signed [ERR_W-1:0] error_x_mm;
	logic signed [ERR_W-1:0] error_y_mm;
	logic [CONF_W-1:0] confidence;
	logic acquired;
	logic descend_ok;

	landing_target_descent_gate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.detected(detected),
		.center_x(center_x),
		.center_y(center_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.error_x_mm(error_x_mm),
		.error_y_mm(error_y_mm),
		.confidence(confidence),
		.acquired(acquired),
		.descend_ok(descend_ok)
	);

	// Predictor copy of the register file.
	logic [MMPP_W-1:0] scale_mmpp;
	logic [SIZE_W-1:0] width_px;
	logic [SIZE_W-1:0] height_px;
	logic [CONF_W-1:0] conf_step;
	logic [CONF_W-1:0] decay_mult;
	logic [CONF_W-1:0] confirm_level;
	logic [ALIGN_W-1:0] align_mm;

	// Predictor copy of the gate state.
	longint conf_level;
	longint err_x_mm;
	longint err_y_mm;
	logic acq_flag;
	logic desc_flag;

	// Result words owed by the block, oldest first.
	gate_word_t pending_words[$];

	int failures = 0;
	int cycle_count = 0;
	// Idle percentages for the sender and the receiver, set per test.
	int gap_pct = 0;
	int stall_pct = 0;
	// Each bump asks the receiver for one long hold-off.
	int hold_requests = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Idle lengths: now and then a long stretch, otherwise a short burst.
	function automatic int burst_len();
		return ($urandom_range(9) == 0) ? $urandom_range(60, 12) : $urandom_range(3, 1);
	endfunction

	// Signed centre offset in millimetres for one axis. The doubled centre is
	// compared against the image size so an odd size is centred exactly; the
	// magnitude is rounded half away from zero and clipped to the error range.
	function automatic longint mm_offset(logic [PIX_W-1:0] c, logic [SIZE_W-1:0] size);
		longint twice;
		longint mid;
		longint mag;
		longint mm;
		twice = longint'(c);
		twice = twice * 2;
		mid = longint'(size);
		mid = mid << PIXEL_FRAC_BITS_DEF;
		mag = (twice < mid) ? mid - twice : twice - mid;
		mm = (mag * longint'(scale_mmpp) + (longint'(1) << (MM_SHIFT - 1))) >> MM_SHIFT;
		if (twice < mid)
			return (mm >= ERR_LIMIT) ? -ERR_LIMIT : -mm;
		return (mm >= ERR_LIMIT) ? ERR_LIMIT - 1 : mm;
	endfunction

	// Advances the predicted gate state by one frame and returns the word the
	// block must produce for it.
	function automatic gate_word_t advance_gate(logic det, logic [PIX_W-1:0] cx,
			logic [PIX_W-1:0] cy);
		gate_word_t w;
		longint dist2;
		longint lim2;
		if (det) begin
			err_x_mm = mm_offset(cx, width_px);
			err_y_mm = mm_offset(cy, height_px);
			conf_level = conf_level + longint'(conf_step);
			if (conf_level > CONF_ONE)
				conf_level = CONF_ONE;
			acq_flag = conf_level >= longint'(confirm_level);
			dist2 = err_x_mm * err_x_mm + err_y_mm * err_y_mm;
			lim2 = longint'(align_mm);
			lim2 = lim2 * lim2;
			desc_flag = acq_flag && (dist2 <= lim2);
		end else begin
			// A missed frame decays the confidence with truncation, keeps the
			// stale errors and always blocks descent. A factor above one may
			// push the product past one, where it is clipped.
			conf_level = (conf_level * longint'(decay_mult)) >> CONF_FRAC_BITS_DEF;
			if (conf_level > CONF_ONE)
				conf_level = CONF_ONE;
			acq_flag = conf_level >= longint'(confirm_level);
			desc_flag = 1'b0;
		end
		w.err_x = err_x_mm[ERR_W-1:0];
		w.err_y = err_y_mm[ERR_W-1:0];
		w.conf = conf_level[CONF_W-1:0];
		w.acq = acq_flag;
		w.desc = desc_flag;
		return w;
	endfunction

	// Scoreboard. Everything is sampled at the rising edge, before the block's
	// own updates land. A result word is checked first, then an accepted
	// observation queues its prediction, then a register write is applied.
	always @(posedge clk) begin
		gate_word_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_words.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS)
						$display("unexpected result word at cycle %0d", cycle_count);
				end else begin
					want = pending_words.pop_front();
					if (error_x_mm !== want.err_x || error_y_mm !== want.err_y ||
							confidence !== want.conf || acquired !== want.acq ||
							descend_ok !== want.desc) begin
						failures++;
						if (failures <= MAX_REPORTS) begin
							$display("mismatch at cycle %0d (expected/actual): err_x %0d/%0d err_y %0d/%0d",
								cycle_count, want.err_x, error_x_mm,
								want.err_y, error_y_mm);
							$display("  conf %0d/%0d acquired %0b/%0b descend_ok %0b/%0b",
								want.conf, confidence, want.acq, acquired,
								want.desc, descend_ok);
						end
					end
				end
			end
			if (in_valid && !in_stall)
				pending_words.push_back(advance_gate(detected, center_x, center_y));
			if (cfg_valid && cfg_ready) begin
				// Each register keeps only its own width of the data; the
				// slot past the list is ignored.
				case (cfg_index)
					REG_MM_PER_PIXEL: scale_mmpp = cfg_data[MMPP_W-1:0];
					REG_IMAGE_WIDTH: width_px = cfg_data[SIZE_W-1:0];
					REG_IMAGE_HEIGHT: height_px = cfg_data[SIZE_W-1:0];
					REG_CONFIDENCE_STEP: conf_step = cfg_data[CONF_W-1:0];
					REG_DECAY_FACTOR: decay_mult = cfg_data[CONF_W-1:0];
					REG_ACQUIRE_LEVEL: confirm_level = cfg_data[CONF_W-1:0];
					REG_ALIGN_THRESHOLD_MM: align_mm = cfg_data[ALIGN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver. It stalls at random in bursts, and on request it holds off for
	// a long stretch so that the block fills up and has to stall its input.
	initial begin
		int stall_run;
		int hold_served;
		stall_run = 0;
		hold_served = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				stall_run = HOLD_CYCLES;
			end
			if (stall_run > 0) begin
				out_stall = 1'b1;
				stall_run--;
			end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				out_stall = 1'b1;
				stall_run = burst_len() - 1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	// Offers one observation word at a falling edge and returns at the falling
	// edge after it was taken, or after a random gap with valid low. Valid stays
	// high when no gap follows, so back to back words are offered without a bubble.
	task automatic send_frame(input logic det, input logic [PIX_W-1:0] cx,
			input logic [PIX_W-1:0] cy);
		detected = det;
		center_x = cx;
		center_y = cy;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			repeat (burst_len()) @(negedge clk);
		end
	endtask

	// Every observation yields exactly one result word, so the block is idle
	// once nothing is owed any more.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
	endtask

	// Writes all register slots in order while the block is idle.
	task automatic load_settings(input reg_file_t s);
		wait_idle();
		for (int i = 0; i < REG_SLOTS; i++) begin
			cfg_index = CFG_IDX_W'(i);
			cfg_data = s[i];
			cfg_valid = 1'b1;
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid = 1'b0;
	endtask

	// Register value that is now and then replaced by a full-width random one,
	// which also covers values past the documented ranges.
	function automatic logic [CFG_W-1:0] maybe_wild(logic [CFG_W-1:0] usual);
		return ($urandom_range(7) == 0) ? CFG_W'($urandom) : usual;
	endfunction

	// Centre coordinate: either anywhere in the field, or close to the image
	// centre so that alignment, and therefore descent, is reachable.
	function automatic logic [PIX_W-1:0] pick_center(logic [SIZE_W-1:0] size, int near_pct);
		longint c;
		int spread;
		if ($urandom_range(99) >= near_pct)
			return PIX_W'($urandom);
		case ($urandom_range(2))
			0: spread = 4;
			1: spread = 64;
			default: spread = 1024;
		endcase
		c = longint'(size);
		c = (c << (PIXEL_FRAC_BITS_DEF - 1)) + longint'($urandom_range(2 * spread)) - spread;
		if (c < 0)
			c = 0;
		if (c > 65535)
			c = 65535;
		return c[PIX_W-1:0];
	endfunction

	// Default registers: exact centre, rounding ties on both sides, the field
	// corners, and missed frames whose coordinates must be ignored.
	task automatic test_directed_defaults();
		gap_pct = 30;
		stall_pct = 30;
		send_frame(1'b1, 16'd5120, 16'd3840);
		send_frame(1'b1, 16'd5128, 16'd3832);
		send_frame(1'b1, 16'd5127, 16'd3833);
		send_frame(1'b1, 16'h0000, 16'h0000);
		send_frame(1'b1, 16'hFFFF, 16'hFFFF);
		send_frame(1'b0, 16'hFFFF, 16'h0000);
		send_frame(1'b0, 16'h0000, 16'hFFFF);
	endtask

	// Register extremes, values past the documented ranges, and the slot
	// past the register list.
	task automatic test_register_extremes();
		reg_file_t s;
		// Largest scale with a zero width and a full-width height: both axes
		// land near the ends of the error range, one high and one low.
		// Full-step detections and a unit decay keep the confidence at one.
		s[REG_MM_PER_PIXEL] = CFG_W'(16'hFFFF);
		s[REG_IMAGE_WIDTH] = '0;
		s[REG_IMAGE_HEIGHT] = CFG_W'(13'h1FFF);
		s[REG_CONFIDENCE_STEP] = CONF_ONE[CFG_W-1:0];
		s[REG_DECAY_FACTOR] = CONF_ONE[CFG_W-1:0];
		s[REG_ACQUIRE_LEVEL] = CONF_ONE[CFG_W-1:0];
		s[REG_ALIGN_THRESHOLD_MM] = CFG_W'(16'hFFFF);
		s[REG_UNUSED] = CFG_W'($urandom);
		load_settings(s);
		send_frame(1'b1, 16'hFFFF, 16'h0000);
		send_frame(1'b1, 16'h0000, 16'hFFF0);
		send_frame(1'b0, 16'h1234, 16'h4321);
		// A zero scale gives zero error, a zero threshold always acquires and
		// a zero align threshold still passes an exact hit. Step and decay
		// above one must saturate.
		s[REG_MM_PER_PIXEL] = '0;
		s[REG_IMAGE_WIDTH] = CFG_W'(13'd1);
		s[REG_IMAGE_HEIGHT] = CFG_W'(13'd4096);
		s[REG_CONFIDENCE_STEP] = '1;
		s[REG_DECAY_FACTOR] = '1;
		s[REG_ACQUIRE_LEVEL] = '0;
		s[REG_ALIGN_THRESHOLD_MM] = '0;
		s[REG_UNUSED] = CFG_W'($urandom);
		load_settings(s);
		send_frame(1'b1, 16'd1234, 16'd5678);
		send_frame(1'b0, 16'hFFFF, 16'hFFFF);
		// Smallest scale, zero decay and zero step: confidence collapses and
		// stays below the smallest threshold.
		s[REG_MM_PER_PIXEL] = CFG_W'(16'd1);
		s[REG_IMAGE_WIDTH] = CFG_W'(13'd4096);
		s[REG_IMAGE_HEIGHT] = CFG_W'(13'd1);
		s[REG_CONFIDENCE_STEP] = '0;
		s[REG_DECAY_FACTOR] = '0;
		s[REG_ACQUIRE_LEVEL] = 17'd1;
		s[REG_UNUSED] = CFG_W'($urandom);
		load_settings(s);
		send_frame(1'b0, 16'h0000, 16'h0000);
		send_frame(1'b1, 16'h0000, 16'hFFFF);
		// Back to a unit scale: a zero align threshold passes only a hit on
		// the exact centre, and a single millimetre off blocks descent.
		s[REG_MM_PER_PIXEL] = CFG_W'(16'd256);
		s[REG_IMAGE_WIDTH] = CFG_W'(13'd640);
		s[REG_IMAGE_HEIGHT] = CFG_W'(13'd480);
		s[REG_CONFIDENCE_STEP] = CONF_ONE[CFG_W-1:0];
		s[REG_DECAY_FACTOR] = 17'd32768;
		s[REG_ACQUIRE_LEVEL] = CONF_ONE[CFG_W-1:0];
		load_settings(s);
		send_frame(1'b1, 16'd5120, 16'd3840);
		send_frame(1'b1, 16'd5136, 16'd3840);
	endtask

	// The receiver holds off for a long stretch while words keep coming, so
	// the output register fills and the block has to stall its input.
	task automatic test_output_hold();
		gap_pct = 0;
		stall_pct = 0;
		wait_idle();
		@(posedge clk);
		hold_requests++;
		@(negedge clk);
		repeat (12)
			send_frame(1'($urandom_range(1)), PIX_W'($urandom), PIX_W'($urandom));
		wait_idle();
	endtask

	// Random phases, each with its own register settings and idle pattern.
	// Most frames are detections, often near the centre so that the confidence
	// climbs and descent opens; the others land anywhere or are misses.
	task automatic test_random_phases();
		reg_file_t s;
		int near_pct;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			s[REG_MM_PER_PIXEL] = maybe_wild(CFG_W'($urandom_range(4096, 16)));
			s[REG_IMAGE_WIDTH] = maybe_wild(CFG_W'($urandom_range(4096, 1)));
			s[REG_IMAGE_HEIGHT] = maybe_wild(CFG_W'($urandom_range(4096, 1)));
			s[REG_CONFIDENCE_STEP] = maybe_wild(CFG_W'($urandom_range(30000, 1000)));
			s[REG_DECAY_FACTOR] = maybe_wild(CFG_W'($urandom_range(65536, 20000)));
			s[REG_ACQUIRE_LEVEL] = maybe_wild(CFG_W'($urandom_range(65536, 1)));
			s[REG_ALIGN_THRESHOLD_MM] = maybe_wild(CFG_W'($urandom_range(2000, 0)));
			s[REG_UNUSED] = CFG_W'($urandom);
			load_settings(s);
			// The first phase runs with no idling on either side.
			gap_pct = (phase == 0) ? 0 : $urandom_range(60);
			stall_pct = (phase == 0) ? 0 : $urandom_range(60);
			near_pct = $urandom_range(90, 40);
			repeat (PHASE_FRAMES)
				send_frame($urandom_range(99) < 75, pick_center(width_px, near_pct),
					pick_center(height_px, near_pct));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		detected = 1'b0;
		center_x = '0;
		center_y = '0;
		// Predictor starts from the reset register values and a cleared state.
		scale_mmpp = MMPP_W'(RST_MMPP);
		width_px = SIZE_W'(RST_WIDTH);
		height_px = SIZE_W'(RST_HEIGHT);
		conf_step = CONF_W'(RST_STEP);
		decay_mult = CONF_W'(RST_DECAY);
		confirm_level = CONF_W'(RST_CONFIRM);
		align_mm = ALIGN_W'(RST_ALIGN);
		conf_level = 0;
		err_x_mm = 0;
		err_y_mm = 0;
		acq_flag = 1'b0;
		desc_flag = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed_defaults();
		test_register_extremes();
		test_output_hold();
		test_random_phases();

		// Everything owed has arrived; a further wait of DRAIN_CYCLES catches any
		// word the block sends on its own.
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending_words.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
design/ltdg_pkg.sv
design/ltdg_cfg.sv
design/ltdg_bsmul.sv
design/ltdg_lane.sv
design/landing_target_descent_gate.sv
design/ltdg_checker.sv
tb/testbench.sv
